@@ rtl/turn_then_drive_goal_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Turn-then-drive goal controller assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TURN_THEN_DRIVE_GOAL_CONTROLLER_MACROS_SVH
`define TURN_THEN_DRIVE_GOAL_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ttd check failed");

// next-cycle implication, disabled in reset
`define TTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ttd check failed");

`endif

@@ rtl/ttd_pkg.sv @@
// ----------------------------------------------------------------------------
// ttd_pkg
// Types, codes and constants of the turn-then-drive goal controller.
// ----------------------------------------------------------------------------
package ttd_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_W     = 36;

    typedef logic signed [31:0]         coord_t;
    typedef logic signed [32:0]         coord_diff_t;
    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic signed [16:0]         angle_t;
    typedef logic signed [18:0]         angle_wide_t;
    typedef logic signed [15:0]         heading_t;

    localparam angle_t      ANG_HALF_PI = 17'sd12868;
    localparam angle_wide_t ANG_TWO_PI  = 19'sd51472;

    localparam logic [1:0] OP_POSE = 2'd0;
    localparam logic [1:0] OP_GOAL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] REG_TOL_X    = 3'd0;
    localparam logic [2:0] REG_TOL_Y    = 3'd1;
    localparam logic [2:0] REG_HEAD_TOL = 3'd2;
    localparam logic [2:0] REG_FWD_SPD  = 3'd3;
    localparam logic [2:0] REG_TURN_SPD = 3'd4;

    localparam logic [30:0] TOL_X_RST    = 31'd6554;
    localparam logic [30:0] TOL_Y_RST    = 31'd6554;
    localparam logic [15:0] HEAD_TOL_RST = 16'd819;
    localparam logic [30:0] FWD_SPD_RST  = 31'd32768;
    localparam logic [30:0] TURN_SPD_RST = 31'd13107;

    typedef enum logic [1:0] {
        ACT_STATUS,
        ACT_REACHED,
        ACT_STEER
    } act_t;

    typedef struct packed {
        act_t     act;
        logic     in_process;
        heading_t heading;
    } tag_t;

    function automatic angle_t atan_entry(input logic [3:0] idx);
        angle_t r;
        case (idx)
            4'd0:    r = 17'sd6434;
            4'd1:    r = 17'sd3798;
            4'd2:    r = 17'sd2007;
            4'd3:    r = 17'sd1019;
            4'd4:    r = 17'sd511;
            4'd5:    r = 17'sd256;
            4'd6:    r = 17'sd128;
            4'd7:    r = 17'sd64;
            4'd8:    r = 17'sd32;
            4'd9:    r = 17'sd16;
            4'd10:   r = 17'sd8;
            4'd11:   r = 17'sd4;
            4'd12:   r = 17'sd2;
            4'd13:   r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/ttd_cordic.sv @@
// ----------------------------------------------------------------------------
// ttd_cordic
// Pipelined vectoring CORDIC atan2, one pre-rotation stage and one
// micro-rotation per stage; a tag word rides along with each entry.
// ----------------------------------------------------------------------------
module ttd_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  ttd_pkg::coord_diff_t in_x,
    input  ttd_pkg::coord_diff_t in_y,
    input  ttd_pkg::tag_t        in_tag,
    output logic                 out_valid,
    output ttd_pkg::angle_t      out_angle,
    output ttd_pkg::tag_t        out_tag
);
    import ttd_pkg::*;

    cordic_t x_reg [0:CORDIC_STEPS];
    cordic_t y_reg [0:CORDIC_STEPS];
    angle_t  z_reg [0:CORDIC_STEPS];
    tag_t    t_reg [0:CORDIC_STEPS];
    logic    v_reg [0:CORDIC_STEPS];

    cordic_t xe, ye, x0_next, y0_next;
    angle_t  z0_next;

    assign xe = CORDIC_W'(in_x);
    assign ye = CORDIC_W'(in_y);

    always_comb begin
        x0_next = xe;
        y0_next = ye;
        z0_next = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = ANG_HALF_PI;
            end else begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
            t_reg[0] <= in_tag;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][CORDIC_W-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(4'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(4'(i));
                end
                t_reg[i+1] <= t_reg[i];
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS];
    assign out_angle = z_reg[CORDIC_STEPS];
    assign out_tag   = t_reg[CORDIC_STEPS];

endmodule

@@ rtl/turn_then_drive_goal_controller.sv @@
// ----------------------------------------------------------------------------
// turn_then_drive_goal_controller
// Keeps pose and goal, answers control ticks with turn, drive or stop words.
//
//   channel  dir  fields
//   s_       in   op, coord_x, coord_y, heading_angle
//   m_       out  kind, linear_velocity, angular_velocity, in_process, last
//   apb      in   tolerance_x/y, heading_tolerance, forward_speed, turn_speed
//
// From acceptance to the first result word a word passes the input register,
// state stage, 15 CORDIC stages, two angle stages and output register.
// One word is accepted per cycle; a goal reach gives two words and holds the
// pipeline until the second is taken. The whole pipeline holds while a result waits.
// Reset clears pose_fresh, active and all valid bits.
// ----------------------------------------------------------------------------
module turn_then_drive_goal_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  ttd_pkg::coord_t      s_coord_x,
    input  ttd_pkg::coord_t      s_coord_y,
    input  ttd_pkg::heading_t    s_heading_angle,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [30:0]          m_linear_velocity,
    output logic signed [31:0]   m_angular_velocity,
    output logic                 m_in_process,
    output logic                 m_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ttd_pkg::*;

    // configuration
    logic [30:0] tol_x_reg, tol_y_reg, fwd_spd_reg, turn_spd_reg;
    logic [15:0] head_tol_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_x_reg    <= TOL_X_RST;
            tol_y_reg    <= TOL_Y_RST;
            head_tol_reg <= HEAD_TOL_RST;
            fwd_spd_reg  <= FWD_SPD_RST;
            turn_spd_reg <= TURN_SPD_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_TOL_X:    tol_x_reg    <= pwdata[30:0];
                REG_TOL_Y:    tol_y_reg    <= pwdata[30:0];
                REG_HEAD_TOL: head_tol_reg <= pwdata[15:0];
                REG_FWD_SPD:  fwd_spd_reg  <= pwdata[30:0];
                REG_TURN_SPD: turn_spd_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_TOL_X:    prdata = {1'b0, tol_x_reg};
            REG_TOL_Y:    prdata = {1'b0, tol_y_reg};
            REG_HEAD_TOL: prdata = {16'd0, head_tol_reg};
            REG_FWD_SPD:  prdata = {1'b0, fwd_spd_reg};
            REG_TURN_SPD: prdata = {1'b0, turn_spd_reg};
            default:      prdata = '0;
        endcase
    end

    // pipeline advance
    logic adv, m_valid_reg, pend_reg;

    assign adv     = !m_valid_reg || (m_ready && !pend_reg);
    assign s_ready = adv;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    coord_t     in_x_reg, in_y_reg;
    heading_t   in_head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_valid) begin
            in_op_reg   <= s_op;
            in_x_reg    <= s_coord_x;
            in_y_reg    <= s_coord_y;
            in_head_reg <= s_heading_angle;
        end
    end

    // state stage
    coord_t      cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    heading_t    cur_head_reg;
    logic        active_reg, fresh_reg, active_next, fresh_next;
    logic        a_valid_reg, a_valid_next;
    tag_t        a_tag_reg, a_tag_next;
    coord_diff_t a_dx_reg, a_dy_reg, dx, dy, tol_x_s, tol_y_s;
    logic        reached;

    assign dx      = 33'(goal_x_reg) - 33'(cur_x_reg);
    assign dy      = 33'(goal_y_reg) - 33'(cur_y_reg);
    assign tol_x_s = {2'b00, tol_x_reg};
    assign tol_y_s = {2'b00, tol_y_reg};
    assign reached = (dx <= tol_x_s) && (dx >= -tol_x_s)
                  && (dy <= tol_y_s) && (dy >= -tol_y_s);

    always_comb begin
        active_next  = active_reg;
        fresh_next   = fresh_reg;
        a_valid_next = 1'b0;
        a_tag_next   = '{act: ACT_STATUS, in_process: 1'b0, heading: cur_head_reg};
        if (in_valid_reg) begin
            case (in_op_reg)
                OP_POSE: begin
                    fresh_next = 1'b1;
                end
                OP_GOAL: begin
                    active_next           = 1'b1;
                    a_valid_next          = 1'b1;
                    a_tag_next.in_process = 1'b1;
                end
                OP_TICK: begin
                    if (!active_reg) begin
                        a_valid_next = 1'b1;
                    end else if (fresh_reg) begin
                        fresh_next   = 1'b0;
                        a_valid_next = 1'b1;
                        if (reached) begin
                            active_next    = 1'b0;
                            a_tag_next.act = ACT_REACHED;
                        end else begin
                            a_tag_next.act = ACT_STEER;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            fresh_reg   <= 1'b0;
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            active_reg  <= active_next;
            fresh_reg   <= fresh_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_tag_reg <= a_tag_next;
            a_dx_reg  <= dx;
            a_dy_reg  <= dy;
            if (in_valid_reg && in_op_reg == OP_POSE) begin
                cur_x_reg    <= in_x_reg;
                cur_y_reg    <= in_y_reg;
                cur_head_reg <= in_head_reg;
            end
            if (in_valid_reg && in_op_reg == OP_GOAL) begin
                goal_x_reg <= in_x_reg;
                goal_y_reg <= in_y_reg;
            end
        end
    end

    // bearing
    logic   c_valid;
    angle_t c_angle;
    tag_t   c_tag;

    ttd_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_x      (a_dx_reg),
        .in_y      (a_dy_reg),
        .in_tag    (a_tag_reg),
        .out_valid (c_valid),
        .out_angle (c_angle),
        .out_tag   (c_tag)
    );

    // normalize to 0..2pi
    logic        d1_valid_reg, d2_valid_reg, d2_gt_reg;
    tag_t        d1_tag_reg, d2_tag_reg;
    angle_wide_t d1_g_reg, d1_h_reg, g_ext, h_ext, diff, d2_ad_reg;

    assign g_ext = 19'(c_angle);
    assign h_ext = 19'(c_tag.heading);
    assign diff  = d1_g_reg - d1_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
        end else if (adv) begin
            d1_valid_reg <= c_valid;
            d2_valid_reg <= d1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_tag_reg <= c_tag;
            d1_g_reg   <= (g_ext < 0) ? g_ext + ANG_TWO_PI : g_ext;
            d1_h_reg   <= (h_ext < 0) ? h_ext + ANG_TWO_PI : h_ext;
            d2_tag_reg <= d1_tag_reg;
            d2_ad_reg  <= (diff < 0) ? -diff : diff;
            d2_gt_reg  <= d1_g_reg > d1_h_reg;
        end
    end

    // turn decision
    angle_wide_t wrap, wrap_abs, right, left;
    logic        turn, turn_right;

    assign wrap       = ANG_TWO_PI - d2_ad_reg;
    assign wrap_abs   = (wrap < 0) ? -wrap : wrap;
    assign right      = d2_gt_reg ? wrap_abs : d2_ad_reg;
    assign left       = d2_gt_reg ? d2_ad_reg : wrap_abs;
    assign turn       = d2_ad_reg > $signed({3'b000, head_tol_reg});
    assign turn_right = right < left;

    // result register
    logic               kind_reg, inproc_reg, last_reg;
    logic [30:0]        lin_reg;
    logic signed [31:0] ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (m_valid_reg && m_ready && pend_reg) begin
            pend_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d2_valid_reg;
            pend_reg    <= d2_valid_reg && (d2_tag_reg.act == ACT_REACHED);
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready && pend_reg) begin
            kind_reg   <= 1'b1;
            lin_reg    <= '0;
            ang_reg    <= '0;
            inproc_reg <= 1'b0;
            last_reg   <= 1'b1;
        end else if (adv) begin
            kind_reg   <= 1'b0;
            lin_reg    <= '0;
            ang_reg    <= '0;
            inproc_reg <= 1'b0;
            last_reg   <= 1'b1;
            case (d2_tag_reg.act)
                ACT_STATUS: begin
                    kind_reg   <= 1'b1;
                    inproc_reg <= d2_tag_reg.in_process;
                end
                ACT_REACHED: begin
                    last_reg <= 1'b0;
                end
                ACT_STEER: begin
                    if (turn) begin
                        ang_reg <= turn_right ? -$signed({1'b0, turn_spd_reg})
                                              : $signed({1'b0, turn_spd_reg});
                    end else begin
                        lin_reg <= fwd_spd_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = kind_reg;
    assign m_linear_velocity  = lin_reg;
    assign m_angular_velocity = ang_reg;
    assign m_in_process       = inproc_reg;
    assign m_last             = last_reg;

endmodule

@@ rtl/ttd_checker.sv @@
// ----------------------------------------------------------------------------
// ttd_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "turn_then_drive_goal_controller_macros.svh"

module ttd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_kind,
    input logic [30:0]        m_linear_velocity,
    input logic signed [31:0] m_angular_velocity,
    input logic               m_in_process,
    input logic               m_last
);

    `TTD_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid)

    `TTD_ASSERT_NEXT(a_word_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_kind) && $stable(m_linear_velocity) && $stable(m_angular_velocity) && $stable(m_last))

    `TTD_ASSERT_SAME(a_status_zero, aclk, aresetn, m_valid && m_kind, m_linear_velocity == 31'd0 && m_angular_velocity == 32'sd0 && m_last)

    `TTD_ASSERT_SAME(a_drive_or_turn, aclk, aresetn, m_valid && !m_kind, !m_in_process && (m_linear_velocity == 31'd0 || m_angular_velocity == 32'sd0))

    `TTD_ASSERT_NEXT(a_stop_then_status, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_kind && !m_in_process && m_last)

endmodule

bind turn_then_drive_goal_controller ttd_checker u_ttd_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_kind             (m_kind),
    .m_linear_velocity  (m_linear_velocity),
    .m_angular_velocity (m_angular_velocity),
    .m_in_process       (m_in_process),
    .m_last             (m_last)
);

@@ verif/turn_then_drive_goal_controller_tb.sv @@
// ----------------------------------------------------------------------------
// turn_then_drive_goal_controller_tb
// Self-checking bench for the goal controller. A directed table covers the
// extremes, every op code, the stale-pose tick and the goal-reached stop; random
// pose/goal/tick streams then run under several register settings. Every result
// word is compared with a steering predictor kept in step with the input words,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module turn_then_drive_goal_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttd_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic       KIND_CMD    = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;
    localparam coord_t     C_MAX       = 32'sh7FFF_FFFF;
    localparam coord_t     C_MIN       = 32'sh8000_0000;
    localparam heading_t   YAW_PI      = 16'sd25736;
    localparam longint     TWO_PI      = 51472;
    localparam longint     ATAN_Q13 [0:CORDIC_STEPS-1] =
        '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    typedef struct packed {
        logic               kind;
        logic [30:0]        lin;
        logic signed [31:0] ang;
        logic               in_proc;
        logic               last;
    } motion_word_t;

    localparam motion_word_t NO_WORD     = '0;
    localparam motion_word_t STATUS_IDLE = '{KIND_STATUS, 31'd0, 32'sd0, 1'b0, 1'b1};
    localparam motion_word_t STATUS_BUSY = '{KIND_STATUS, 31'd0, 32'sd0, 1'b1, 1'b1};
    localparam motion_word_t STOP_CMD    = '{KIND_CMD, 31'd0, 32'sd0, 1'b0, 1'b0};

    typedef struct {
        logic [1:0]   op;
        coord_t       x;
        coord_t       y;
        heading_t     hdg;
        int           typed;
        motion_word_t w0;
        motion_word_t w1;
    } probe_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = OP_POSE;
    coord_t             s_coord_x = '0;
    coord_t             s_coord_y = '0;
    heading_t           s_heading_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_kind;
    logic [30:0]        m_linear_velocity;
    logic signed [31:0] m_angular_velocity;
    logic               m_in_process;
    logic               m_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state and register copy
    coord_t      pose_x = '0;
    coord_t      pose_y = '0;
    heading_t    pose_hdg = '0;
    coord_t      aim_x = '0;
    coord_t      aim_y = '0;
    logic        aim_active = 1'b0;
    logic        pose_new = 1'b0;
    logic [30:0] tol_x = TOL_X_RST;
    logic [30:0] tol_y = TOL_Y_RST;
    logic [15:0] hdg_tol = HEAD_TOL_RST;
    logic [30:0] fwd_spd = FWD_SPD_RST;
    logic [30:0] turn_spd = TURN_SPD_RST;

    motion_word_t pending_cmds [$];
    probe_t       probes [$];
    int           mismatches = 0;
    logic         tx_burst = 1'b0;
    logic         rx_burst = 1'b0;
    int           rx_hold = 0;

    turn_then_drive_goal_controller u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_coord_x          (s_coord_x),
        .s_coord_y          (s_coord_y),
        .s_heading_angle    (s_heading_angle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_linear_velocity  (m_linear_velocity),
        .m_angular_velocity (m_angular_velocity),
        .m_in_process       (m_in_process),
        .m_last             (m_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #10 aclk = ~aclk;

    function automatic longint abs_q(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint bearing_q13(input longint dy, input longint dx);
        longint xr, yr, z, t, xs, ys;
        xr = dx;
        yr = dy;
        z = 0;
        if (xr < 0) begin
            t = xr;
            if (yr >= 0) begin
                xr = yr;
                yr = -t;
                z = longint'(ANG_HALF_PI);
            end else begin
                xr = -yr;
                yr = t;
                z = -longint'(ANG_HALF_PI);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr >= 0) begin
                xr = xr + ys;
                yr = yr - xs;
                z = z + ATAN_Q13[i];
            end else begin
                xr = xr - ys;
                yr = yr + xs;
                z = z - ATAN_Q13[i];
            end
        end
        return z;
    endfunction

    function automatic int compute_steering(input logic [1:0] op, input coord_t x,
            input coord_t y, input heading_t hdg,
            output motion_word_t w0, output motion_word_t w1);
        longint dx, dy, g, h, right_arc, left_arc;
        w0 = NO_WORD;
        w1 = NO_WORD;
        case (op)
            OP_POSE: begin
                pose_x = x;
                pose_y = y;
                pose_hdg = hdg;
                pose_new = 1'b1;
                return 0;
            end
            OP_GOAL: begin
                aim_x = x;
                aim_y = y;
                aim_active = 1'b1;
                w0 = STATUS_BUSY;
                return 1;
            end
            OP_TICK: ;
            default: return 0;
        endcase
        if (!aim_active) begin
            w0 = STATUS_IDLE;
            return 1;
        end
        if (!pose_new) return 0;
        pose_new = 1'b0;
        dx = longint'(aim_x) - longint'(pose_x);
        dy = longint'(aim_y) - longint'(pose_y);
        if (abs_q(dx) <= longint'(tol_x) && abs_q(dy) <= longint'(tol_y)) begin
            aim_active = 1'b0;
            w0 = STOP_CMD;
            w1 = STATUS_IDLE;
            return 2;
        end
        g = bearing_q13(dy, dx);
        if (g < 0) g = g + TWO_PI;
        h = longint'(pose_hdg);
        if (h < 0) h = h + TWO_PI;
        w0.kind = KIND_CMD;
        w0.last = 1'b1;
        if (abs_q(g - h) > longint'(hdg_tol)) begin
            if (g > h) begin
                right_arc = abs_q(TWO_PI - g + h);
                left_arc = abs_q(g - h);
            end else begin
                right_arc = abs_q(h - g);
                left_arc = abs_q(TWO_PI - h + g);
            end
            w0.ang = (right_arc < left_arc) ? -$signed({1'b0, turn_spd})
                                            : $signed({1'b0, turn_spd});
        end else begin
            w0.lin = fwd_spd;
        end
        return 1;
    endfunction

    function automatic coord_t pick_coord();
        if ($urandom_range(0, 2) == 0) return coord_t'($urandom);
        return coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] want,
            input logic signed [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic add_row(input logic [1:0] op, input coord_t x, input coord_t y,
            input heading_t hdg, input int typed, input motion_word_t w0,
            input motion_word_t w1);
        probe_t p;
        p.op = op;
        p.x = x;
        p.y = y;
        p.hdg = hdg;
        p.typed = typed;
        p.w0 = w0;
        p.w1 = w1;
        probes.push_back(p);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TOL_X:    tol_x = data[30:0];
            REG_TOL_Y:    tol_y = data[30:0];
            REG_HEAD_TOL: hdg_tol = data[15:0];
            REG_FWD_SPD:  fwd_spd = data[30:0];
            REG_TURN_SPD: turn_spd = data[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_word(input logic [1:0] op, input coord_t x, input coord_t y,
            input heading_t hdg, input int typed, input motion_word_t t0,
            input motion_word_t t1);
        int gap, n;
        motion_word_t w0, w1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_coord_x <= x;
        s_coord_y <= y;
        s_heading_angle <= hdg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = compute_steering(op, x, y, hdg, w0, w1);
        if (typed >= 0) begin
            n = typed;
            w0 = t0;
            w1 = t1;
        end
        if (n > 0) pending_cmds.push_back(w0);
        if (n > 1) pending_cmds.push_back(w1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cmds.size() != 0);
    endtask

    task automatic run_random(input int count);
        int done, sel, span, r;
        logic [1:0] op;
        coord_t x, y;
        heading_t hdg;
        longint g;
        done = 0;
        while (done < count) begin
            sel = $urandom_range(0, 99);
            x = pick_coord();
            y = pick_coord();
            hdg = heading_t'($urandom);
            if (sel < 10) begin
                op = OP_GOAL;
            end else if (sel < 50) begin
                op = OP_POSE;
                // land near the goal most of the time so stops and small bearings show up
                if ($urandom_range(0, 3) != 0) begin
                    span = ($urandom_range(0, 4) == 0) ? 0 :
                           (($urandom_range(0, 1) == 0) ? 10000 : (1 << 20));
                    x = aim_x + coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
                    y = aim_y + coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
                end
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    // aim roughly along the bearing to hit the drive-forward window
                    g = bearing_q13(longint'(aim_y) - longint'(y),
                                    longint'(aim_x) - longint'(x));
                    if (g < 0) g = g + TWO_PI;
                    g = g + longint'($urandom_range(0, 2400)) - 1200;
                    if (g > longint'(YAW_PI)) g = g - TWO_PI;
                    hdg = heading_t'(g);
                end else if (r < 9) begin
                    hdg = heading_t'($urandom_range(0, 51472) - 25736);
                end
            end else if (sel < 96) begin
                op = OP_TICK;
            end else begin
                op = OP_UNUSED;
            end
            send_word(op, x, y, hdg, -1, NO_WORD, NO_WORD);
            if (op != OP_UNUSED) done++;
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
    endtask

    always @(posedge aclk) begin : rx_side
        motion_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else if (m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                mismatches++;
                $display("%0t: word with nothing expected, expected none, got kind %0d",
                         $time, m_kind);
            end else begin
                want = pending_cmds.pop_front();
                compare_field("kind", want.kind, m_kind);
                compare_field("linear_velocity", want.lin, m_linear_velocity);
                compare_field("angular_velocity", want.ang, m_angular_velocity);
                compare_field("in_process", want.in_proc, m_in_process);
                compare_field("last", want.last, m_last);
            end
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            rx_hold = rx_burst ? 0 : $urandom_range(0, 19);
            if (rx_hold != 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            if (rx_hold == 0) m_ready <= 1'b1;
            else rx_hold--;
        end
    end

    initial begin
        #20_000_000;
        $display("turn_then_drive_goal_controller_tb failed");
        $finish;
    end

    initial begin
        int phase;
        logic [30:0] tx, ty, fs, ts;
        logic [15:0] ht;

        add_row(OP_TICK, 0, 0, 0, 1, STATUS_IDLE, NO_WORD);
        add_row(OP_UNUSED, C_MAX, C_MIN, -1, 0, NO_WORD, NO_WORD);
        add_row(OP_GOAL, 0, 0, 0, 1, STATUS_BUSY, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, 0, NO_WORD, NO_WORD);
        add_row(OP_POSE, 0, 0, 0, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, 2, STOP_CMD, STATUS_IDLE);
        add_row(OP_TICK, 0, 0, 0, 1, STATUS_IDLE, NO_WORD);
        add_row(OP_GOAL, C_MAX, C_MAX, 0, 1, STATUS_BUSY, NO_WORD);
        add_row(OP_POSE, C_MIN, C_MIN, -YAW_PI, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, -1, NO_WORD, NO_WORD);
        add_row(OP_POSE, C_MIN, C_MIN, YAW_PI, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, C_MAX, C_MAX, YAW_PI, -1, NO_WORD, NO_WORD);
        add_row(OP_GOAL, C_MIN, C_MAX, 0, 1, STATUS_BUSY, NO_WORD);
        add_row(OP_POSE, C_MAX, C_MIN, 0, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, -1, NO_WORD, NO_WORD);
        add_row(OP_GOAL, C_MIN, C_MIN, 0, 1, STATUS_BUSY, NO_WORD);
        add_row(OP_POSE, C_MAX, C_MAX, 16'sh7FFF, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, -1, NO_WORD, NO_WORD);
        add_row(OP_POSE, C_MAX, C_MAX, 16'sh8000, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, C_MIN, C_MIN, -1, -1, NO_WORD, NO_WORD);
        add_row(OP_GOAL, 655360, 0, 0, 1, STATUS_BUSY, NO_WORD);
        add_row(OP_POSE, 0, 0, 0, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, -1, NO_WORD, NO_WORD);
        add_row(OP_POSE, 648806, 6554, 0, 0, NO_WORD, NO_WORD);
        add_row(OP_TICK, 0, 0, 0, 2, STOP_CMD, STATUS_IDLE);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < probes.size(); k++) begin
            send_word(probes[k].op, probes[k].x, probes[k].y, probes[k].hdg,
                      probes[k].typed, probes[k].w0, probes[k].w1);
        end

        for (phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                // let words that give no result leave the pipeline before touching registers
                wait_drained();
                repeat (40) @(posedge aclk);
                case (phase)
                    1: begin
                        tx = '0; ty = '0; ht = '0; fs = '0; ts = '0;
                    end
                    2: begin
                        tx = '1; ty = '1; ht = 16'd51472; fs = '1; ts = '1;
                    end
                    default: begin
                        tx = 31'($urandom_range(0, 100000));
                        ty = 31'($urandom_range(0, 100000));
                        ht = 16'($urandom_range(0, 51472));
                        fs = 31'($urandom);
                        ts = 31'($urandom);
                    end
                endcase
                apb_write(REG_TOL_X, {1'b0, tx});
                apb_write(REG_TOL_Y, {1'b0, ty});
                apb_write(REG_HEAD_TOL, {16'd0, ht});
                apb_write(REG_FWD_SPD, {1'b0, fs});
                apb_write(REG_TURN_SPD, {1'b0, ts});
            end
            run_random(170);
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("turn_then_drive_goal_controller_tb passed");
        end else begin
            $display("turn_then_drive_goal_controller_tb failed");
        end
        $finish;
    end

endmodule
